// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. All of them sample on aclk and stay quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// The condition must never be true.
`define RV_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/rv64ce_pkg.sv =====
package rv64ce_pkg;

    localparam int XLEN = 64;

    typedef enum logic [1:0] {
        KIND_RETIRE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_TRAP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_LW    = 3'd1,
        PEND_LD    = 3'd2,
        PEND_FLD   = 3'd3,
        PEND_STORE = 3'd4
    } pend_kind_t;

    localparam logic [3:0] CAUSE_ILLEGAL = 4'd2;
    localparam logic [3:0] CAUSE_BREAK   = 4'd3;

    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_SP = 5'd2;

    localparam logic [1:0] QUAD0 = 2'd0;
    localparam logic [1:0] QUAD1 = 2'd1;
    localparam logic [1:0] QUAD2 = 2'd2;

    typedef struct packed {
        logic             op;
        logic [15:0]      instr;
        logic [XLEN-1:0]  next_pc;
        logic [XLEN-1:0]  load_data;
        logic             fault;
        logic [3:0]       fault_cause;
        logic [XLEN-1:0]  fault_value;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [XLEN-1:0]  new_pc;
        logic [XLEN-1:0]  mem_address;
        logic [XLEN-1:0]  mem_store_data;
        logic             mem_doubleword;
        logic [3:0]       trap_cause;
        logic [XLEN-1:0]  trap_value;
        logic             fp_dirty;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [4:0]       addr;
        logic [XLEN-1:0]  data;
    } wr_t;

    typedef struct packed {
        pend_kind_t       kind;
        logic [4:0]       dest;
        logic [XLEN-1:0]  ret_pc;
    } pend_t;

    // Integer read port A: sp, rd or the compressed rs1'.
    function automatic logic [4:0] port_a_addr(input logic [15:0] w);
        logic [4:0] a;
        a = w[11:7];
        case (w[1:0])
            QUAD0: a = (w[15:13] == 3'd0) ? REG_SP : {2'b01, w[9:7]};
            QUAD1: a = (w[15] && !(w[14:13] == 2'd1)) ? {2'b01, w[9:7]} : w[11:7];
            QUAD2: a = (w[15:13] == 3'd0 || w[15:13] == 3'd4) ? w[11:7] : REG_SP;
            default: a = w[11:7];
        endcase
        return a;
    endfunction

    // Integer read port B, also the float read address: rs2' in quadrants 0 and 1, rs2 in 2.
    function automatic logic [4:0] port_b_addr(input logic [15:0] w);
        return (w[1:0] == QUAD2) ? w[6:2] : {2'b01, w[4:2]};
    endfunction

endpackage

// ===== hw/rtl/rv64ce_rf_bank.sv =====
module rv64ce_rf_bank (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rv64ce_pkg::wr_t           wr,
    input  logic                      rd_en,
    input  logic [4:0]                rd_addr,
    output logic [rv64ce_pkg::XLEN-1:0] rd_data
);
    import rv64ce_pkg::*;

    logic [XLEN-1:0] mem [32];
    logic [31:0]     valid_reg;
    logic [XLEN-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // A write in the same cycle is forwarded; an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rd_addr) begin
                rd_data_reg <= wr.data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= mem[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rv64ce_exec.sv =====
module rv64ce_exec (
    input  rv64ce_pkg::item_t             item,
    input  logic [rv64ce_pkg::XLEN-1:0]   ra,
    input  logic [rv64ce_pkg::XLEN-1:0]   rb,
    input  logic [rv64ce_pkg::XLEN-1:0]   fb,
    input  rv64ce_pkg::pend_t             pend,
    output rv64ce_pkg::res_t              res,
    output rv64ce_pkg::wr_t               iwr,
    output rv64ce_pkg::wr_t               fwr,
    output rv64ce_pkg::pend_t             pend_next
);
    import rv64ce_pkg::*;

    logic [15:0]     w;
    logic [2:0]      f3;
    logic [XLEN-1:0] npc, pc, imm6, sum, diff, lsa;
    logic [5:0]      sh;
    logic            illegal, req;
    logic [4:0]      rd, rs2, rdp, rsp;
    wr_t             iw;
    logic [9:0]      imm4spn;
    logic [XLEN-1:0] imm16, imm12, imm9;

    always_comb begin
        w        = item.instr;
        f3       = w[15:13];
        npc      = item.next_pc;
        pc       = npc - XLEN'(2);
        rd       = w[11:7];
        rs2      = w[6:2];
        rdp      = {2'b01, w[4:2]};
        rsp      = {2'b01, w[9:7]};
        sh       = {w[12], w[6:2]};
        imm6     = {{(XLEN-6){w[12]}}, w[12], w[6:2]};
        imm4spn  = {w[10:7], w[12:11], w[5], w[6], 2'b00};
        imm16    = {{(XLEN-10){w[12]}}, w[12], w[4:3], w[5], w[2], w[6], 4'b0};
        imm12    = {{(XLEN-12){w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11],
                    w[5:3], 1'b0};
        imm9     = {{(XLEN-9){w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
        sum      = ra + rb;
        diff     = ra - rb;
        lsa      = '0;
        illegal  = 1'b0;
        req      = 1'b0;
        iw       = '0;
        fwr      = '0;
        res      = '0;
        res.kind = KIND_RETIRE;
        res.new_pc = npc;
        pend_next = pend;
        pend_next.kind = PEND_NONE;

        if (item.op) begin
            if (pend.kind != PEND_NONE) begin
                if (item.fault) begin
                    res.kind       = KIND_TRAP;
                    res.new_pc     = pend.ret_pc - XLEN'(2);
                    res.trap_cause = item.fault_cause;
                    res.trap_value = item.fault_value;
                end else begin
                    res.new_pc   = pend.ret_pc;
                    res.fp_dirty = (pend.kind == PEND_FLD);
                    case (pend.kind)
                        PEND_LW: iw = '{1'b1, pend.dest,
                                        {{32{item.load_data[31]}}, item.load_data[31:0]}};
                        PEND_LD: iw = '{1'b1, pend.dest, item.load_data};
                        PEND_FLD: fwr = '{1'b1, pend.dest, item.load_data};
                        default: iw = '0;
                    endcase
                end
            end
        end else begin
            case (w[1:0])
                QUAD0: begin
                    if (f3 == 3'd2 || f3 == 3'd6) begin
                        lsa = ra + XLEN'({w[5], w[12:10], w[6], 2'b00});
                    end else begin
                        lsa = ra + XLEN'({w[6:5], w[12:10], 3'b000});
                    end
                    res.mem_address = lsa;
                    case (f3)
                        3'd0: begin
                            if (imm4spn == '0) illegal = 1'b1;
                            else iw = '{1'b1, rdp, ra + XLEN'(imm4spn)};
                        end
                        3'd1: begin
                            req = 1'b1; res.kind = KIND_READ; res.mem_doubleword = 1'b1;
                            pend_next.kind = PEND_FLD;
                        end
                        3'd2: begin
                            req = 1'b1; res.kind = KIND_READ; pend_next.kind = PEND_LW;
                        end
                        3'd3: begin
                            req = 1'b1; res.kind = KIND_READ; res.mem_doubleword = 1'b1;
                            pend_next.kind = PEND_LD;
                        end
                        3'd5: begin
                            req = 1'b1; res.kind = KIND_WRITE; res.mem_doubleword = 1'b1;
                            res.mem_store_data = fb; pend_next.kind = PEND_STORE;
                        end
                        3'd6: begin
                            req = 1'b1; res.kind = KIND_WRITE;
                            res.mem_store_data = {32'b0, rb[31:0]};
                            pend_next.kind = PEND_STORE;
                        end
                        3'd7: begin
                            req = 1'b1; res.kind = KIND_WRITE; res.mem_doubleword = 1'b1;
                            res.mem_store_data = rb; pend_next.kind = PEND_STORE;
                        end
                        default: illegal = 1'b1;
                    endcase
                    pend_next.dest = (f3[2]) ? 5'd0 : rdp;
                end
                QUAD1: begin
                    case (f3)
                        3'd0: iw = '{1'b1, rd, ra + imm6};
                        3'd1: begin
                            lsa = ra + imm6;
                            iw  = '{1'b1, rd, {{32{lsa[31]}}, lsa[31:0]}};
                        end
                        3'd2: iw = '{1'b1, rd, imm6};
                        3'd3: begin
                            if (rd == REG_SP) begin
                                if (imm16 == '0) illegal = 1'b1;
                                else iw = '{1'b1, REG_SP, ra + imm16};
                            end else begin
                                iw = '{1'b1, rd, {{(XLEN-18){w[12]}}, w[12], w[6:2], 12'b0}};
                            end
                        end
                        3'd4: begin
                            case (w[11:10])
                                2'd0: iw = '{1'b1, rsp, ra >> sh};
                                2'd1: iw = '{1'b1, rsp, XLEN'($signed(ra) >>> sh)};
                                2'd2: iw = '{1'b1, rsp, ra & imm6};
                                default: begin
                                    if (!w[12]) begin
                                        case (w[6:5])
                                            2'd0: iw = '{1'b1, rsp, diff};
                                            2'd1: iw = '{1'b1, rsp, ra ^ rb};
                                            2'd2: iw = '{1'b1, rsp, ra | rb};
                                            default: iw = '{1'b1, rsp, ra & rb};
                                        endcase
                                    end else begin
                                        case (w[6:5])
                                            2'd0: iw = '{1'b1, rsp,
                                                         {{32{diff[31]}}, diff[31:0]}};
                                            2'd1: iw = '{1'b1, rsp,
                                                         {{32{sum[31]}}, sum[31:0]}};
                                            default: illegal = 1'b1;
                                        endcase
                                    end
                                end
                            endcase
                        end
                        3'd5: res.new_pc = pc + imm12;
                        default: begin
                            if ((ra == '0) == (f3 == 3'd6)) res.new_pc = pc + imm9;
                        end
                    endcase
                end
                QUAD2: begin
                    case (f3)
                        3'd0: iw = '{1'b1, rd, ra << sh};
                        3'd1, 3'd3: begin
                            req = 1'b1; res.kind = KIND_READ; res.mem_doubleword = 1'b1;
                            res.mem_address = ra + XLEN'({w[4:2], w[12], w[6:5], 3'b000});
                            pend_next.kind = (f3 == 3'd1) ? PEND_FLD : PEND_LD;
                            pend_next.dest = rd;
                        end
                        3'd2: begin
                            req = 1'b1; res.kind = KIND_READ;
                            res.mem_address = ra + XLEN'({w[3:2], w[12], w[6:4], 2'b00});
                            pend_next.kind = PEND_LW;
                            pend_next.dest = rd;
                        end
                        3'd4: begin
                            if (!w[12]) begin
                                if (rs2 == '0) res.new_pc = {ra[XLEN-1:1], 1'b0};
                                else iw = '{1'b1, rd, rb};
                            end else if (rs2 == '0 && rd == '0) begin
                                res.kind       = KIND_TRAP;
                                res.new_pc     = pc;
                                res.trap_cause = CAUSE_BREAK;
                                res.trap_value = pc;
                            end else if (rs2 == '0) begin
                                res.new_pc = {ra[XLEN-1:1], 1'b0};
                                iw = '{1'b1, REG_RA, npc};
                            end else begin
                                iw = '{1'b1, rd, sum};
                            end
                        end
                        3'd6: begin
                            req = 1'b1; res.kind = KIND_WRITE;
                            res.mem_address = ra + XLEN'({w[8:7], w[12:9], 2'b00});
                            res.mem_store_data = {32'b0, rb[31:0]};
                            pend_next.kind = PEND_STORE;
                            pend_next.dest = '0;
                        end
                        default: begin
                            req = 1'b1; res.kind = KIND_WRITE; res.mem_doubleword = 1'b1;
                            res.mem_address = ra + XLEN'({w[9:7], w[12:10], 3'b000});
                            res.mem_store_data = (f3 == 3'd5) ? fb : rb;
                            pend_next.kind = PEND_STORE;
                            pend_next.dest = '0;
                        end
                    endcase
                end
                default: illegal = 1'b1;
            endcase

            if (req) begin
                res.new_pc       = '0;
                pend_next.ret_pc = npc;
            end else begin
                pend_next.kind = PEND_NONE;
                pend_next.dest = pend.dest;
                res.mem_address = '0;
            end
            if (illegal) begin
                iw             = '0;
                res            = '0;
                res.kind       = KIND_TRAP;
                res.new_pc     = pc;
                res.trap_cause = CAUSE_ILLEGAL;
                res.trap_value = XLEN'(w);
            end
        end

        // Register x0 is never written.
        iwr    = iw;
        iwr.en = iw.en && (iw.addr != '0);
    end

endmodule

// ===== hw/rtl/rv64c_compressed_executor.sv =====
// Executes one RV64C compressed instruction per transfer and can take one item in every
// cycle. The accepting edge captures the item together with the integer and floating-point
// register reads, with forwarding from the instruction ahead. When the item advances, the
// result is computed into the output register and written back. While the output register
// holds a result that the receiver has not taken, the item behind it waits and the input
// stalls. Loads and stores produce a memory request. A later response item (tuser = 1)
// completes the pending access. Both register files read as zero after reset.
`include "assert_macros.svh"

module rv64c_compressed_executor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instruction[15:0], next_pc[79:16], load_data[143:80], access_fault[144],
    // fault_cause[148:145], fault_value[212:149], zero fill
    input  logic [215:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pc[63:0], mem_address[127:64], mem_store_data[191:128], mem_doubleword[192],
    // trap_cause[196:193], trap_value[260:197], fp_dirty[261], zero fill
    output logic [263:0] m_tdata,
    // result_kind
    output logic [1:0]   m_tuser
);
    import rv64ce_pkg::*;

    logic            s1_valid_reg, s1_valid_next;
    item_t           s1_reg;
    logic            out_valid_reg, out_valid_next;
    res_t            out_reg;
    pend_t           pend_reg;
    logic            accept, advance;
    logic [15:0]     s_instr;
    logic [XLEN-1:0] ra, rb, fb;
    res_t            res;
    wr_t             iwr, fwr;
    wr_t             iwr_raw, fwr_raw;
    pend_t           pend_next;
    logic            res_is_req;

    assign s_instr  = s_tdata[15:0];
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Two copies of the integer file give two read ports with one shared write.
    rv64ce_rf_bank u_int_a (
        .aclk(aclk), .aresetn(aresetn), .wr(iwr), .rd_en(accept),
        .rd_addr(port_a_addr(s_instr)), .rd_data(ra)
    );
    rv64ce_rf_bank u_int_b (
        .aclk(aclk), .aresetn(aresetn), .wr(iwr), .rd_en(accept),
        .rd_addr(port_b_addr(s_instr)), .rd_data(rb)
    );
    rv64ce_rf_bank u_fp (
        .aclk(aclk), .aresetn(aresetn), .wr(fwr), .rd_en(accept),
        .rd_addr(port_b_addr(s_instr)), .rd_data(fb)
    );

    rv64ce_exec u_exec (
        .item(s1_reg), .ra(ra), .rb(rb), .fb(fb), .pend(pend_reg),
        .res(res), .iwr(iwr_raw), .fwr(fwr_raw), .pend_next(pend_next)
    );

    // Write-back only happens when the item moves into the output register.
    always_comb begin
        iwr    = iwr_raw;
        iwr.en = iwr_raw.en && advance;
        fwr    = fwr_raw;
        fwr.en = fwr_raw.en && advance;
    end

    assign res_is_req = (res.kind == KIND_READ) || (res.kind == KIND_WRITE);

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '{PEND_NONE, 5'd0, '0};
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= '{s_tuser, s_tdata[15:0], s_tdata[79:16], s_tdata[143:80],
                        s_tdata[144], s_tdata[148:145], s_tdata[212:149]};
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {2'b00, out_reg.fp_dirty, out_reg.trap_value, out_reg.trap_cause,
                       out_reg.mem_doubleword, out_reg.mem_store_data, out_reg.mem_address,
                       out_reg.new_pc};

    `RV_ASSERT_NEXT(a_req_sets_pending, advance && res_is_req, pend_reg.kind != PEND_NONE)
    `RV_ASSERT_NEVER(a_no_x0_write, iwr.en && iwr.addr == 5'd0)
    `RV_ASSERT_IMPL(a_dirty_on_retire, m_tvalid && m_tdata[261], m_tuser == KIND_RETIRE)
    `RV_ASSERT_IMPL(a_single_write, iwr.en || fwr.en, advance && !(iwr.en && fwr.en))

endmodule

// ===== dv/tb.sv =====
module tb;
    import rv64ce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit          op;
        logic [15:0] instr;
        logic [63:0] npc;
        logic [63:0] data;
        bit          fault;
        logic [3:0]  cause;
        logic [63:0] fval;
    } stim_t;

    typedef struct {
        stim_t s;
        bit    typed;
        res_t  want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic [1:0]   m_tuser;

    rv64c_compressed_executor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow architectural state.
    logic [63:0] xreg [32];
    logic [63:0] freg [32];
    pend_kind_t  pend_kind;
    logic [4:0]  pend_dest;
    logic [63:0] pend_ret;

    res_t  result_q [$];
    int    mismatches;
    kind_t last_kind;
    row_t  dir_rows [$];

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic void xwr(input logic [4:0] r, input logic [63:0] v);
        if (r != 5'd0) xreg[r] = v;
    endfunction

    function automatic res_t blank();
        res_t r;
        r = '0;
        r.kind = KIND_RETIRE;
        return r;
    endfunction

    function automatic res_t mem_req(input kind_t k, input logic [63:0] a,
                                     input logic [63:0] d, input bit dw,
                                     input pend_kind_t pk, input logic [4:0] dest,
                                     input logic [63:0] npc);
        res_t r;
        r = blank();
        pend_kind = pk;
        pend_dest = dest;
        pend_ret  = npc;
        r.kind = k;
        r.mem_address = a;
        r.mem_store_data = d;
        r.mem_doubleword = dw;
        return r;
    endfunction

    function automatic res_t illegal_trap(input logic [63:0] pc, input logic [15:0] w);
        res_t r;
        r = blank();
        r.kind = KIND_TRAP;
        r.new_pc = pc;
        r.trap_cause = CAUSE_ILLEGAL;
        r.trap_value = {48'd0, w};
        return r;
    endfunction

    function automatic res_t execute(input stim_t s);
        res_t r;
        logic [15:0] w;
        logic [63:0] npc, pc, imm, a, v, t, sv;
        logic [2:0] f3;
        logic [4:0] rdp, rsp, rd, rs2;
        logic [5:0] sh;
        pend_kind_t k;
        r = blank();
        if (s.op) begin
            if (pend_kind == PEND_NONE) begin
                r.new_pc = s.npc;
                return r;
            end
            k = pend_kind;
            pend_kind = PEND_NONE;
            if (s.fault) begin
                r.kind = KIND_TRAP;
                r.new_pc = pend_ret - 64'd2;
                r.trap_cause = s.cause;
                r.trap_value = s.fval;
                return r;
            end
            case (k)
                PEND_LW:  xwr(pend_dest, sx32(s.data));
                PEND_LD:  xwr(pend_dest, s.data);
                PEND_FLD: freg[pend_dest] = s.data;
                default: ;
            endcase
            r.new_pc = pend_ret;
            r.fp_dirty = (k == PEND_FLD);
            return r;
        end
        pend_kind = PEND_NONE;
        w = s.instr;
        npc = s.npc;
        pc = npc - 64'd2;
        f3 = w[15:13];
        rdp = {2'b01, w[4:2]};
        rsp = {2'b01, w[9:7]};
        rd = w[11:7];
        rs2 = w[6:2];
        sh = {w[12], w[6:2]};
        case (w[1:0])
            QUAD0: begin
                if (f3 == 3'd2 || f3 == 3'd6)
                    imm = {57'd0, w[5], w[12:10], w[6], 2'b00};
                else
                    imm = {56'd0, w[6:5], w[12:10], 3'b000};
                a = xreg[rsp] + imm;
                case (f3)
                    3'd0: begin
                        imm = {54'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
                        if (imm == 64'd0) return illegal_trap(pc, w);
                        xwr(rdp, xreg[2] + imm);
                    end
                    3'd1: return mem_req(KIND_READ, a, 0, 1, PEND_FLD, rdp, npc);
                    3'd2: return mem_req(KIND_READ, a, 0, 0, PEND_LW, rdp, npc);
                    3'd3: return mem_req(KIND_READ, a, 0, 1, PEND_LD, rdp, npc);
                    3'd5: return mem_req(KIND_WRITE, a, freg[rdp], 1, PEND_STORE, 0, npc);
                    3'd6: return mem_req(KIND_WRITE, a, {32'd0, xreg[rdp][31:0]}, 0,
                                         PEND_STORE, 0, npc);
                    3'd7: return mem_req(KIND_WRITE, a, xreg[rdp], 1, PEND_STORE, 0, npc);
                    default: return illegal_trap(pc, w);
                endcase
            end
            QUAD1: begin
                imm = {{59{w[12]}}, w[6:2]};
                case (f3)
                    3'd0: xwr(rd, xreg[rd] + imm);
                    3'd1: xwr(rd, sx32(xreg[rd] + imm));
                    3'd2: xwr(rd, imm);
                    3'd3: begin
                        if (rd == REG_SP) begin
                            imm = {{55{w[12]}}, w[4:3], w[5], w[2], w[6], 4'b0000};
                            if (imm == 64'd0) return illegal_trap(pc, w);
                            xreg[2] = xreg[2] + imm;
                        end else begin
                            xwr(rd, {{47{w[12]}}, w[6:2], 12'd0});
                        end
                    end
                    3'd4: begin
                        v = xreg[rsp];
                        sv = xreg[rdp];
                        case (w[11:10])
                            2'd0: xwr(rsp, v >> sh);
                            2'd1: xwr(rsp, $signed(v) >>> sh);
                            2'd2: xwr(rsp, v & imm);
                            default: begin
                                if (!w[12]) begin
                                    case (w[6:5])
                                        2'd0: xwr(rsp, v - sv);
                                        2'd1: xwr(rsp, v ^ sv);
                                        2'd2: xwr(rsp, v | sv);
                                        default: xwr(rsp, v & sv);
                                    endcase
                                end else begin
                                    case (w[6:5])
                                        2'd0: xwr(rsp, sx32(v - sv));
                                        2'd1: xwr(rsp, sx32(v + sv));
                                        default: return illegal_trap(pc, w);
                                    endcase
                                end
                            end
                        endcase
                    end
                    3'd5: begin
                        imm = {{53{w[12]}}, w[8], w[10:9], w[6], w[7], w[2], w[11],
                               w[5:3], 1'b0};
                        npc = pc + imm;
                    end
                    default: begin
                        imm = {{56{w[12]}}, w[6:5], w[2], w[11:10], w[4:3], 1'b0};
                        if ((xreg[rsp] == 64'd0) == (f3 == 3'd6)) npc = pc + imm;
                    end
                endcase
            end
            QUAD2: begin
                case (f3)
                    3'd0: xwr(rd, xreg[rd] << sh);
                    3'd1, 3'd3: begin
                        a = xreg[2] + {55'd0, w[4:2], w[12], w[6:5], 3'b000};
                        return mem_req(KIND_READ, a, 0, 1,
                                       (f3 == 3'd1) ? PEND_FLD : PEND_LD, rd, npc);
                    end
                    3'd2: begin
                        a = xreg[2] + {56'd0, w[3:2], w[12], w[6:4], 2'b00};
                        return mem_req(KIND_READ, a, 0, 0, PEND_LW, rd, npc);
                    end
                    3'd4: begin
                        if (!w[12]) begin
                            if (rs2 == 5'd0) npc = xreg[rd] & ~64'd1;
                            else xwr(rd, xreg[rs2]);
                        end else if (rs2 == 5'd0 && rd == 5'd0) begin
                            r.kind = KIND_TRAP;
                            r.new_pc = pc;
                            r.trap_cause = CAUSE_BREAK;
                            r.trap_value = pc;
                            return r;
                        end else if (rs2 == 5'd0) begin
                            t = npc;
                            npc = xreg[rd] & ~64'd1;
                            xreg[1] = t;
                        end else begin
                            xwr(rd, xreg[rd] + xreg[rs2]);
                        end
                    end
                    3'd6: begin
                        a = xreg[2] + {56'd0, w[8:7], w[12:9], 2'b00};
                        return mem_req(KIND_WRITE, a, {32'd0, xreg[rs2][31:0]}, 0,
                                       PEND_STORE, 0, npc);
                    end
                    default: begin
                        a = xreg[2] + {55'd0, w[9:7], w[12:10], 3'b000};
                        return mem_req(KIND_WRITE, a, (f3 == 3'd5) ? freg[rs2] : xreg[rs2],
                                       1, PEND_STORE, 0, npc);
                    end
                endcase
            end
            default: return illegal_trap(pc, w);
        endcase
        xreg[0] = 64'd0;
        r.new_pc = npc;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(input stim_t s, input bit typed, input res_t want, input bit busy);
        res_t p;
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= s.op;
        s_tdata  <= {3'd0, s.fval, s.cause, s.fault, s.data, s.npc, s.instr};
        do @(posedge aclk); while (!s_tready);
        p = execute(s);
        last_kind = p.kind;
        result_q.push_back(typed ? want : p);
        g = busy ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic stim_t rand_stim(input bit op);
        stim_t s;
        s.op = op;
        s.instr = 16'($urandom);
        if ($urandom_range(0, 19) != 0) s.instr[1:0] = 2'($urandom_range(0, 2));
        s.npc = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) s.npc[63:16] = '0;
        s.data = {$urandom, $urandom};
        s.fault = ($urandom_range(0, 6) == 0);
        s.cause = 4'($urandom);
        s.fval = {$urandom, $urandom};
        return s;
    endfunction

    function automatic void add_row(input bit op, input logic [15:0] w,
                                    input logic [63:0] npc, input logic [63:0] data,
                                    input bit fault, input bit typed, input res_t want);
        row_t r;
        r.s.op = op;
        r.s.instr = w;
        r.s.npc = npc;
        r.s.data = data;
        r.s.fault = fault;
        r.s.cause = 4'd5;
        r.s.fval = 64'hDEAD_BEEF_0000_1234;
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    // Receiver: random stalls plus one long hold-off that backs up the pipeline.
    initial begin
        int cyc;
        int hold;
        cyc = 0;
        hold = 0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= 1500 && cyc < 1900) begin
                m_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20) hold = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.new_pc = m_tdata[63:0];
            got.mem_address = m_tdata[127:64];
            got.mem_store_data = m_tdata[191:128];
            got.mem_doubleword = m_tdata[192];
            got.trap_cause = m_tdata[196:193];
            got.trap_value = m_tdata[260:197];
            got.fp_dirty = m_tdata[261];
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer kind=%0d", m_tuser);
            end else begin
                exp_r = result_q.pop_front();
                if (got.kind !== exp_r.kind || got.new_pc !== exp_r.new_pc ||
                    got.mem_address !== exp_r.mem_address ||
                    got.mem_store_data !== exp_r.mem_store_data ||
                    got.mem_doubleword !== exp_r.mem_doubleword ||
                    got.trap_cause !== exp_r.trap_cause ||
                    got.trap_value !== exp_r.trap_value ||
                    got.fp_dirty !== exp_r.fp_dirty) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp kind=%0d pc=%h addr=%h data=%h dw=%b",
                                 exp_r.kind, exp_r.new_pc, exp_r.mem_address,
                                 exp_r.mem_store_data, exp_r.mem_doubleword);
                        $display("         exp cause=%0d tval=%h dirty=%b", exp_r.trap_cause,
                                 exp_r.trap_value, exp_r.fp_dirty);
                        $display("         got kind=%0d pc=%h addr=%h data=%h dw=%b",
                                 got.kind, got.new_pc, got.mem_address,
                                 got.mem_store_data, got.mem_doubleword);
                        $display("         got cause=%0d tval=%h dirty=%b", got.trap_cause,
                                 got.trap_value, got.fp_dirty);
                    end
                end
            end
        end
    end

    initial begin
        res_t e;
        res_t none;
        stim_t s;
        int wait_cyc;
        mismatches = 0;
        for (int i = 0; i < 32; i++) begin
            xreg[i] = '0;
            freg[i] = '0;
        end
        pend_kind = PEND_NONE;
        pend_dest = '0;
        pend_ret = '0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        s_tdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        none = blank();
        // Response with nothing pending retires at the given pc.
        e = blank();
        e.new_pc = '1;
        add_row(1, 16'h0000, '1, '1, 0, 1, e);
        // Zero-immediate C.ADDI4SPN and a quadrant three word are illegal.
        add_row(0, 16'h0000, 64'd2, 0, 0, 1, illegal_trap(64'd0, 16'h0000));
        add_row(0, 16'hFFFF, 64'd0, 0, 0, 1, illegal_trap('1 - 64'd1, 16'hFFFF));
        e = blank();
        e.kind = KIND_TRAP;
        e.new_pc = 64'h1000;
        e.trap_cause = CAUSE_BREAK;
        e.trap_value = 64'h1000;
        add_row(0, 16'h9002, 64'h1002, 0, 0, 1, e);
        add_row(0, 16'h6082, 64'h40, 0, 0, 0, none);      // C.LDSP x1
        add_row(1, 16'h0000, 64'h0, '1, 0, 0, none);
        add_row(0, 16'h8082, 64'h80, 0, 0, 0, none);      // C.JR x1
        add_row(0, 16'h6181, 64'h84, 0, 0, 0, none);      // C.LUI zero immediate
        add_row(0, 16'h8002, 64'h88, 0, 0, 0, none);      // C.JR x0
        add_row(0, 16'h6101, 64'h8C, 0, 0, 1, illegal_trap(64'h8A, 16'h6101));
        add_row(0, 16'h9C41, 64'h90, 0, 0, 1, illegal_trap(64'h8E, 16'h9C41));
        add_row(0, 16'h4000, 64'h2002, 0, 0, 0, none);    // C.LW, then a faulting response
        add_row(1, 16'h0000, 64'h0, 0, 1, 0, none);
        add_row(0, 16'h2000, 64'h3002, 0, 0, 0, none);    // C.FLD
        add_row(1, 16'h0000, 64'h0, 64'h8000_0000_0000_0001, 0, 0, none);
        add_row(0, 16'h4002, 64'h3006, 0, 0, 0, none);    // C.LWSP to x0
        add_row(1, 16'h0000, 64'h0, 64'h8000_0000, 0, 0, none);
        add_row(0, 16'h6000, 64'h4002, 0, 0, 0, none);    // load dropped by next instruction
        add_row(0, 16'h0505, 64'h4004, 0, 0, 0, none);
        add_row(1, 16'h0000, 64'h5555, 0, 0, 0, none);
        add_row(0, 16'h9082, 64'h6002, 0, 0, 0, none);    // C.JALR x1
        add_row(0, 16'hE000, 64'h6004, 0, 0, 0, none);    // C.SD
        add_row(1, 16'h0000, 64'h0, 0, 0, 0, none);
        add_row(0, 16'hA000, 64'h6006, 0, 0, 0, none);    // C.FSD
        add_row(0, 16'hC006, 64'h6008, 0, 0, 0, none);    // C.SWSP

        foreach (dir_rows[i])
            send(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want, 1'b0);

        // Mostly instruction plus response pairs, with stray responses and dropped accesses.
        for (int n = 0; n < 1400; n++) begin
            bit busy;
            busy = ((n / 64) % 4 == 1);
            s = rand_stim($urandom_range(0, 19) == 0);
            send(s, 0, none, busy);
            if (!s.op && (last_kind == KIND_READ || last_kind == KIND_WRITE) &&
                $urandom_range(0, 9) != 0) begin
                send(rand_stim(1), 0, none, busy);
                n++;
            end
        end
        s_tvalid <= 1'b0;

        wait_cyc = 0;
        while (result_q.size() != 0 && wait_cyc < 100000) begin
            @(posedge aclk);
            wait_cyc++;
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
